[rtl/tcce_pkg.sv]
package tcce_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int PROD_W = ROW_W + COL_W + 1;

  // Field widths of the channels.
  localparam int CH_W   = 8;
  localparam int FG_W   = 4;
  localparam int ADDR_W = 11;
  localparam int ATTR_W = 8;
  localparam int STEP_W = 3;

  // Control characters.
  localparam logic [CH_W-1:0] CH_NULL      = 8'd0;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CH_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'd32;

  // Result kinds.
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  // Operation decoded from one character.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_NEWLINE,
    OP_TAB,
    OP_BACKSPACE,
    OP_PRINT
  } op_t;

  // Cursor movement applied by one step.
  typedef enum logic [1:0] {
    MV_NONE,
    MV_NEWLINE,
    MV_ADVANCE,
    MV_BACK
  } move_t;

endpackage

[rtl/tcce_char_if.sv]
interface tcce_char_if;
  import tcce_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic [FG_W-1:0] fg_color;

  modport source (output valid, ch, fg_color, input ready);
  modport sink   (input valid, ch, fg_color, output ready);
endinterface

[rtl/tcce_result_if.sv]
interface tcce_result_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] address;
  logic [CH_W-1:0]   glyph;
  logic [ATTR_W-1:0] attr;
  logic              last;

  modport source (output valid, kind, address, glyph, attr, last, input ready);
  modport sink   (input valid, kind, address, glyph, attr, last, output ready);
endinterface

[rtl/text_console_cursor_engine.sv]
// Text console cursor engine for an 80x25 character screen.
// The chars channel takes one character byte with a foreground color per item.
// The results channel gives cell writes (kind 0) and cursor updates (kind 1),
// each with a linear cell address; last marks the final result of a character.
// Newline and backspace give two results, a printable byte three, a tab six,
// and a null byte or a backspace at the top-left corner none.
// Results leave one per cycle from an output register while the receiver is ready;
// an accepted item is first captured in the item register, and its first result
// is then loaded into the output register. The next item is accepted in the
// cycle its final result is loaded (or, for an item with no results, in the
// cycle it finishes), so items follow back to back.
// When the receiver holds ready low, the output register holds its result
// and the step sequencer waits; the chars channel is held off once the
// current item still has results to go.
// Reset puts the cursor at row 0, column 0 and drops any pending item and
// result. The line-end table is not cleared; backspacing into a line that
// was never finished is not supported.
module text_console_cursor_engine (
  input  logic                 clk,
  input  logic                 rst,
  tcce_char_if.sink            chars,
  tcce_result_if.source        results
);
  import tcce_pkg::*;

  // Cursor and line-end table.
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [COL_W-1:0] line_end [ROWS];

  // Item being worked on.
  logic              job_valid;
  op_t               job_op;
  logic [CH_W-1:0]   job_ch;
  logic [FG_W-1:0]   job_fg;
  logic [STEP_W-1:0] job_step;

  // Step decode.
  logic            step_emit;
  logic            step_kind;
  logic [CH_W-1:0] step_glyph;
  logic            step_new_pos;
  logic            step_done;
  move_t           step_move;

  logic             advance;
  logic             out_free;
  logic             le_we;
  logic [COL_W-1:0] le_data;
  logic [COL_W:0]   col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [ROW_W-1:0] row_prev;
  logic [COL_W-1:0] le_prev;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col;
  logic [PROD_W-1:0] pos_lin;
  op_t              in_op;

  // Decode of an incoming character.
  always_comb begin
    if (chars.ch == CH_NEWLINE) begin
      in_op = OP_NEWLINE;
    end else if (chars.ch == CH_TAB) begin
      in_op = OP_TAB;
    end else if (chars.ch == CH_BACKSPACE) begin
      in_op = OP_BACKSPACE;
    end else if (chars.ch == CH_NULL) begin
      in_op = OP_NONE;
    end else begin
      in_op = OP_PRINT;
    end
  end

  // Per-step sequence of each operation.
  always_comb begin
    step_emit    = 1'b0;
    step_kind    = KIND_WRITE;
    step_glyph   = CH_NULL;
    step_new_pos = 1'b0;
    step_done    = 1'b1;
    step_move    = MV_NONE;
    unique case (job_op)
      OP_NEWLINE: begin
        step_emit = 1'b1;
        if (job_step == STEP_W'(0)) begin
          step_kind    = KIND_CURSOR;
          step_move    = MV_NEWLINE;
          step_new_pos = 1'b1;
          step_done    = 1'b0;
        end
      end
      OP_TAB: begin
        step_emit = 1'b1;
        if (job_step < STEP_W'(4)) begin
          step_glyph = CH_SPACE;
          step_move  = MV_ADVANCE;
          step_done  = 1'b0;
        end else if (job_step == STEP_W'(4)) begin
          step_kind = KIND_CURSOR;
          step_done = 1'b0;
        end
      end
      OP_BACKSPACE: begin
        if (job_step == STEP_W'(0)) begin
          if (cur_col != '0 || cur_row != '0) begin
            step_emit    = 1'b1;
            step_kind    = KIND_CURSOR;
            step_move    = MV_BACK;
            step_new_pos = 1'b1;
            step_done    = 1'b0;
          end
        end else begin
          step_emit = 1'b1;
        end
      end
      OP_PRINT: begin
        step_emit = 1'b1;
        if (job_step == STEP_W'(0)) begin
          step_glyph = job_ch;
          step_move  = MV_ADVANCE;
          step_done  = 1'b0;
        end else if (job_step == STEP_W'(1)) begin
          step_done = 1'b0;
        end else begin
          step_kind = KIND_CURSOR;
        end
      end
      default: begin
        step_emit = 1'b0;
      end
    endcase
  end

  // Cursor movement.
  assign col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
  assign row_inc  = (cur_row < ROW_W'(ROWS - 1)) ? cur_row + ROW_W'(1) : cur_row;
  assign row_prev = cur_row - ROW_W'(1);
  assign le_prev  = line_end[row_prev];

  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    le_we        = 1'b0;
    le_data      = cur_col;
    unique case (step_move)
      MV_NEWLINE: begin
        le_we        = 1'b1;
        le_data      = cur_col;
        cur_col_next = '0;
        cur_row_next = row_inc;
      end
      MV_ADVANCE: begin
        if (col_inc >= (COL_W+1)'(COLUMNS)) begin
          le_we        = 1'b1;
          le_data      = COL_W'(COLUMNS - 1);
          cur_col_next = '0;
          cur_row_next = row_inc;
        end else begin
          cur_col_next = col_inc[COL_W-1:0];
        end
      end
      MV_BACK: begin
        if (cur_col != '0) begin
          cur_col_next = cur_col - COL_W'(1);
        end else begin
          cur_row_next = row_prev;
          if ({1'b0, le_prev} >= (COL_W+1)'(COLUMNS)) begin
            cur_col_next = COL_W'(COLUMNS - 1);
          end else begin
            cur_col_next = le_prev;
          end
        end
      end
      default: begin
        cur_row_next = cur_row;
      end
    endcase
  end

  // Linear cell address of the result.
  assign pos_row = step_new_pos ? cur_row_next : cur_row;
  assign pos_col = step_new_pos ? cur_col_next : cur_col;
  assign pos_lin = PROD_W'(pos_row) * PROD_W'(COLUMNS) + PROD_W'(pos_col);

  // Handshake control.
  assign out_free    = !results.valid || results.ready;
  assign advance     = job_valid && (!step_emit || out_free);
  assign chars.ready = !job_valid || (advance && step_done);

  // Item register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_op    <= OP_NONE;
      job_step  <= '0;
    end else if (chars.valid && chars.ready) begin
      job_valid <= 1'b1;
      job_op    <= in_op;
      job_step  <= '0;
    end else if (advance) begin
      if (step_done) begin
        job_valid <= 1'b0;
      end else begin
        job_step <= job_step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      job_ch <= chars.ch;
      job_fg <= chars.fg_color;
    end
  end

  // Cursor registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (advance) begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // Line-end table; holds unknown contents until each line is finished.
  always_ff @(posedge clk) begin
    if (advance && le_we) begin
      line_end[cur_row] <= le_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= advance && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      results.kind    <= step_kind;
      results.address <= ADDR_W'(pos_lin);
      results.glyph   <= step_glyph;
      results.attr    <= (step_kind == KIND_CURSOR) ? '0 : ATTR_W'(job_fg);
      results.last    <= step_done;
    end
  end

`ifndef SYNTHESIS
  // The cursor always stays on the screen.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (COL_W+1)'(cur_col) < (COL_W+1)'(COLUMNS))
    else $error("cursor column off screen");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    (ROW_W+1)'(cur_row) < (ROW_W+1)'(ROWS))
    else $error("cursor row off screen");

  // No operation runs past its sixth step.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_step <= STEP_W'(5))
    else $error("step counter out of range");

  // An accepted item is always taken up by the sequencer.
  a_accept_job: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.ready) |=> job_valid)
    else $error("accepted item lost");
`endif

endmodule

[tb/sv/tb_text_console_cursor_engine.sv]
// One result of the engine: a cell write or a cursor position update.
typedef struct packed {
  logic                        kind;
  logic [tcce_pkg::ADDR_W-1:0] address;
  logic [tcce_pkg::CH_W-1:0]   glyph;
  logic [tcce_pkg::ATTR_W-1:0] attr;
  logic                        last;
} console_op_t;

// Tracks the cursor and the line-end table, and holds the cell operations
// that accepted characters are still owed.
class console_checker;
  logic [tcce_pkg::ROW_W-1:0] row;
  logic [tcce_pkg::COL_W-1:0] col;
  logic [tcce_pkg::COL_W-1:0] line_end [tcce_pkg::ROWS];
  console_op_t                char_ops [$];
  console_op_t                pending_ops [$];
  int                         errors;

  function new();
    row    = '0;
    col    = '0;
    errors = 0;
    foreach (line_end[i]) line_end[i] = '0;
  endfunction

  // Queue one operation at the current cursor position.
  function void emit(logic kind, logic [tcce_pkg::CH_W-1:0] glyph,
                     logic [tcce_pkg::ATTR_W-1:0] attr);
    console_op_t op;
    int          lin;
    lin        = int'(row) * tcce_pkg::COLUMNS + int'(col);
    op.kind    = kind;
    op.address = lin[tcce_pkg::ADDR_W-1:0];
    op.glyph   = glyph;
    op.attr    = attr;
    op.last    = 1'b0;
    char_ops.push_back(op);
  endfunction

  // The row sticks at the bottom of the screen; there is no scrolling.
  function void advance_row();
    if (row < tcce_pkg::ROWS - 1) row++;
  endfunction

  // Step right, wrapping to the next row as soon as the column runs off.
  function void advance_col();
    if (int'(col) + 1 >= tcce_pkg::COLUMNS) begin
      line_end[row] = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
      col = '0;
      advance_row();
    end else begin
      col++;
    end
  endfunction

  // Work out the operations one accepted character causes.
  function void note_char(logic [tcce_pkg::CH_W-1:0] ch, logic [tcce_pkg::FG_W-1:0] fg);
    tcce_pkg::op_t               op;
    logic [tcce_pkg::ATTR_W-1:0] attr;
    attr = tcce_pkg::ATTR_W'(fg);
    char_ops.delete();
    case (ch)
      tcce_pkg::CH_NULL:      op = tcce_pkg::OP_NONE;
      tcce_pkg::CH_NEWLINE:   op = tcce_pkg::OP_NEWLINE;
      tcce_pkg::CH_TAB:       op = tcce_pkg::OP_TAB;
      tcce_pkg::CH_BACKSPACE: op = tcce_pkg::OP_BACKSPACE;
      default:                op = tcce_pkg::OP_PRINT;
    endcase

    case (op)
      tcce_pkg::OP_NEWLINE: begin
        line_end[row] = col;
        col = '0;
        advance_row();
        emit(tcce_pkg::KIND_CURSOR, '0, '0);
        emit(tcce_pkg::KIND_WRITE, '0, attr);
      end
      tcce_pkg::OP_TAB: begin
        repeat (4) begin
          emit(tcce_pkg::KIND_WRITE, tcce_pkg::CH_SPACE, attr);
          advance_col();
        end
        emit(tcce_pkg::KIND_CURSOR, '0, '0);
        emit(tcce_pkg::KIND_WRITE, '0, attr);
      end
      tcce_pkg::OP_BACKSPACE: begin
        // At column 0 go back to where the previous line ended; at the
        // top-left corner nothing moves and nothing comes out.
        if (col != 0) begin
          col--;
          emit(tcce_pkg::KIND_CURSOR, '0, '0);
          emit(tcce_pkg::KIND_WRITE, '0, attr);
        end else if (row != 0) begin
          row--;
          col = line_end[row];
          if (col >= tcce_pkg::COLUMNS) col = tcce_pkg::COL_W'(tcce_pkg::COLUMNS - 1);
          emit(tcce_pkg::KIND_CURSOR, '0, '0);
          emit(tcce_pkg::KIND_WRITE, '0, attr);
        end
      end
      tcce_pkg::OP_PRINT: begin
        emit(tcce_pkg::KIND_WRITE, ch, attr);
        advance_col();
        emit(tcce_pkg::KIND_WRITE, '0, attr);
        emit(tcce_pkg::KIND_CURSOR, '0, '0);
      end
      default: ;
    endcase

    if (char_ops.size() > 0) char_ops[char_ops.size() - 1].last = 1'b1;
    foreach (char_ops[i]) pending_ops.push_back(char_ops[i]);
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // Compare one accepted result with the oldest owed operation.
  function void check_result(console_op_t got);
    console_op_t want;
    if (pending_ops.size() == 0) begin
      $error("unexpected result: kind %0d address %0d glyph %0d attr %0d last %0d",
             got.kind, got.address, got.glyph, got.attr, got.last);
      errors++;
      return;
    end
    want = pending_ops.pop_front();
    compare_field("kind", int'(want.kind), int'(got.kind));
    compare_field("address", int'(want.address), int'(got.address));
    compare_field("glyph", int'(want.glyph), int'(got.glyph));
    compare_field("attr", int'(want.attr), int'(got.attr));
    compare_field("last", int'(want.last), int'(got.last));
  endfunction

  function int pending();
    return pending_ops.size();
  endfunction
endclass

module tb_text_console_cursor_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 20;
  localparam int PHASE_ITEMS    = 32;
  localparam int NUM_DIRECTED   = 18;

  logic clk;
  logic rst;

  tcce_char_if   chars_if ();
  tcce_result_if results_if ();

  text_console_cursor_engine u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  console_checker board;

  int send_idle_pct;
  int stall_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int quiet;

  // Directed opening: corner backspace, null, byte extremes, every control
  // character, and backspaces that climb back over finished lines.
  logic [CH_W-1:0] dir_ch [NUM_DIRECTED] = '{
    CH_BACKSPACE, CH_NULL, 8'd65, 8'd255, 8'd1, CH_TAB, CH_BACKSPACE,
    CH_NEWLINE, CH_BACKSPACE, CH_NEWLINE, CH_NEWLINE, CH_BACKSPACE,
    CH_BACKSPACE, 8'd127, 8'd128, 8'd11, 8'd7, CH_BACKSPACE
  };
  logic [FG_W-1:0] dir_fg [NUM_DIRECTED] = '{
    4'd5, 4'd15, 4'd15, 4'd0, 4'd10, 4'd3, 4'd12, 4'd9, 4'd1,
    4'd6, 4'd0, 4'd4, 4'd2, 4'd7, 4'd8, 4'd14, 4'd15, 4'd0
  };

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one character, with random idle cycles ahead of it.
  task automatic send_char(input logic [CH_W-1:0] ch, input logic [FG_W-1:0] fg);
    while (($urandom % 100) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk);
    end
    chars_if.valid    <= 1'b1;
    chars_if.ch       <= ch;
    chars_if.fg_color <= fg;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    board.note_char(ch, fg);
  endtask

  // Stop offering and wait until every owed result has been taken.
  task automatic wait_drained();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // One random stretch of typing; returns how many characters it sent.
  task automatic send_burst(output int count);
    int              pick;
    int              len;
    logic [CH_W-1:0] b;
    pick  = $urandom_range(0, 99);
    count = 0;
    if (pick < 40) begin
      // A short line of text and tabs, closed by a newline.
      len = $urandom_range(1, 12);
      repeat (len) begin
        if ($urandom_range(0, 2) == 0) begin
          b = CH_TAB;
        end else begin
          do b = CH_W'($urandom_range(1, 255));
          while (b == CH_BACKSPACE || b == CH_TAB || b == CH_NEWLINE);
        end
        send_char(b, FG_W'($urandom_range(0, 15)));
      end
      send_char(CH_NEWLINE, FG_W'($urandom_range(0, 15)));
      count = len + 1;
    end else if (pick < 60) begin
      // Blank lines push the cursor toward the bottom row.
      len = $urandom_range(3, 8);
      repeat (len) send_char(CH_NEWLINE, FG_W'($urandom_range(0, 15)));
      count = len;
    end else if (pick < 70) begin
      // A run of tabs, long enough to wrap from column 8 on, often in the middle of a tab.
      len = $urandom_range(18, 22);
      repeat (len) send_char(CH_TAB, FG_W'($urandom_range(0, 15)));
      count = len;
    end else if (pick < 85) begin
      len = $urandom_range(1, 8);
      repeat (len) send_char(CH_BACKSPACE, FG_W'($urandom_range(0, 15)));
      count = len;
    end else begin
      send_char(CH_W'($urandom_range(0, 255)), FG_W'($urandom_range(0, 15)));
      count = 1;
    end
  endtask

  // Result side: check accepted results and drive ready, with random stalls
  // and, on request, one long hold-off.
  initial begin
    hold_seen = 0;
    hold_left = 0;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && results_if.valid && results_if.ready) begin
        board.check_result({results_if.kind, results_if.address, results_if.glyph,
                            results_if.attr, results_if.last});
      end
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= (($urandom % 100) >= stall_pct);
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  initial begin
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (chars_if.valid && chars_if.ready) ||
          (results_if.valid && results_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_text_console_cursor_engine: done, errors");
    $finish;
  end

  // Main sequence: reset, directed characters, then four phases of sender idling and receiver stalls.
  initial begin
    int sent;
    int n;
    board = new();
    send_idle_pct = 0;
    rst               <= 1'b1;
    chars_if.valid    <= 1'b0;
    chars_if.ch       <= '0;
    chars_if.fg_color <= '0;
    stall_pct         <= 0;
    hold_reqs         <= 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) send_char(dir_ch[i], dir_fg[i]);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          // No idling, but the receiver first holds off for a long time
          // while characters keep coming.
          send_idle_pct = 0;
          stall_pct    <= 0;
          hold_reqs    <= hold_reqs + 1;
        end
        1: begin
          send_idle_pct = 73;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 73;
        end
        default: begin
          send_idle_pct = 34;
          stall_pct    <= 34;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        send_burst(n);
        sent += n;
      end
      wait_drained();
    end

    // Give any stray result time to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_text_console_cursor_engine: done, clean");
    end else begin
      $display("tb_text_console_cursor_engine: done, errors");
    end
    $finish;
  end

endmodule
